// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. All checks run on i_clk and are
// held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mems_pkg.sv =====
// ----------------------------------------------------------------------------
// mems_pkg
// Types, constants and control bundles for the mouse event motion smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package mems_pkg;

    localparam int WIN_MAX = 64;
    localparam int WIN_AW  = $clog2(WIN_MAX);
    localparam int CNT_W   = WIN_AW + 1;
    localparam int DELTA_W = 16;
    localparam int SUM_W   = DELTA_W + CNT_W + 1;
    localparam int DVD_W   = SUM_W + 16;
    localparam int DIV_CW  = $clog2(DVD_W);
    localparam int ALPHA_W = 17;
    localparam int CFG_W   = 17;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

    // register indexes
    typedef enum logic [1:0] {
        REG_ALPHA   = 2'd0,
        REG_USE_MA  = 2'd1,
        REG_WIN_SZ  = 2'd2,
        REG_NONE    = 2'd3
    } t_reg_idx;

    // event types and codes
    localparam logic [15:0] EV_SYN = 16'd0;
    localparam logic [15:0] EV_KEY = 16'd1;
    localparam logic [15:0] EV_REL = 16'd2;
    localparam logic [15:0] KEY_RIGHT = 16'h0111;
    localparam logic [15:0] KEY_LEFT  = 16'h0110;
    localparam logic [15:0] KEY_KPMIN = 16'd74;
    localparam logic [15:0] KEY_KPPLS = 16'd78;
    localparam logic [15:0] REL_X     = 16'd0;
    localparam logic [15:0] REL_Y     = 16'd1;
    localparam logic [15:0] REL_Z     = 16'd2;
    localparam logic [15:0] REL_WHEEL = 16'd8;

    // event kinds
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_CURSOR = 3'd1;
    localparam logic [2:0] KIND_RIGHT  = 3'd2;
    localparam logic [2:0] KIND_LEFT   = 3'd3;
    localparam logic [2:0] KIND_BTN_B  = 3'd4;
    localparam logic [2:0] KIND_BTN_A  = 3'd5;
    localparam logic [2:0] KIND_WHEEL  = 3'd6;

    typedef struct packed {
        logic               func;
        logic [15:0]        ev_type;
        logic [15:0]        ev_code;
        logic signed [31:0] ev_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         event_kind;
        logic [1:0]         button_state;
        logic signed [15:0] rel_x;
        logic signed [15:0] rel_y;
        logic signed [15:0] rel_z;
        logic signed [15:0] rel_scroll;
        logic signed [31:0] filtered_x;
        logic signed [31:0] filtered_y;
        logic signed [31:0] filtered_z;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_UPD, S_RD, S_POP, S_PUSH, S_FILT,
        S_DIV, S_DFIN, S_MUL, S_ADD, S_LOAD
    } t_state;

    typedef struct packed {
        logic take_in;
        logic pop;
        logic push;
        logic filt_init;
        logic div_step;
        logic div_fin;
        logic mul;
        logic sm_wr;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_emits;
        logic is_cursor;
        logic cnt_gt;
        logic cnt_lt;
        logic cnt_zero;
        logic use_ma;
        logic div_last;
        logic axis_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/core/mems_ram.sv =====
// ----------------------------------------------------------------------------
// mems_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mems_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/mems_ctrl.sv =====
// ----------------------------------------------------------------------------
// mems_ctrl
// Sequencer: window update, filter pass and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mems_ctrl import mems_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_stall,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_both, n_both;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_both  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_both  <= n_both;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_both  = r_both;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_stat.in_emits) n_state = S_UPD;
            end
            S_UPD: begin
                n_both = 1'b0;
                if (!i_stat.is_cursor) begin
                    n_state = S_FILT;
                end else if (i_stat.cnt_gt) begin
                    n_state = S_RD;
                end else if (i_stat.cnt_lt) begin
                    n_state = S_PUSH;
                end else if (!i_stat.cnt_zero) begin
                    // full window: drop oldest then append
                    n_state = S_RD;
                    n_both  = 1'b1;
                end else begin
                    n_state = S_FILT;
                end
            end
            S_RD:   n_state = S_POP;
            S_POP:  n_state = r_both ? S_PUSH : S_FILT;
            S_PUSH: n_state = S_FILT;
            S_FILT: begin
                if (!i_stat.use_ma)       n_state = S_MUL;
                else if (i_stat.cnt_zero) n_state = S_LOAD;
                else                      n_state = S_DIV;
            end
            S_DIV:  if (i_stat.div_last) n_state = S_DFIN;
            S_DFIN: n_state = S_LOAD;
            S_MUL:  n_state = S_ADD;
            S_ADD:  n_state = i_stat.axis_last ? S_LOAD : S_MUL;
            S_LOAD: if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.take_in = i_in_valid;
            end
            S_POP:  o_cmd.pop       = 1'b1;
            S_PUSH: o_cmd.push      = 1'b1;
            S_FILT: o_cmd.filt_init = 1'b1;
            S_DIV:  o_cmd.div_step  = 1'b1;
            S_DFIN: o_cmd.div_fin   = 1'b1;
            S_MUL:  o_cmd.mul       = 1'b1;
            S_ADD:  o_cmd.sm_wr     = 1'b1;
            S_LOAD: o_cmd.load_out  = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

    `ASSERT_IMPL(a_div_mode, r_state == S_DIV, i_stat.use_ma, "divider runs outside mean mode")
    `ASSERT_NEXT(a_both_push, r_state == S_POP && r_both, r_state == S_PUSH, "missed re-append")

endmodule

`default_nettype wire

// ===== rtl/core/mems_dp.sv =====
// ----------------------------------------------------------------------------
// mems_dp
// Held record, window store and sums, serial dividers and smoother.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mems_dp import mems_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire t_in_item         i_in_data,
    input  wire t_cmd             i_cmd,
    output t_stat                 o_stat,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_data
);

    // configuration
    logic [ALPHA_W-1:0] r_alpha;
    logic               r_use_ma;
    logic [6:0]         r_win_sz;

    // held record
    logic [2:0]                r_kind;
    logic [1:0]                r_button;
    logic signed [DELTA_W-1:0] r_held [4];
    logic                      r_motion;

    // window
    logic [CNT_W-1:0]        r_count;
    logic [WIN_AW-1:0]       r_head;
    logic signed [SUM_W-1:0] r_sum_x, r_sum_y;
    logic [2*DELTA_W-1:0]    ram_rdata;
    logic [CNT_W-1:0]        target;

    // filters
    logic signed [31:0]      r_smooth [3];
    logic [DVD_W-1:0]        r_dvd_x, r_dvd_y;
    logic [CNT_W-1:0]        r_rem_x, r_rem_y;
    logic                    r_neg_x, r_neg_y;
    logic [DIV_CW-1:0]       r_div_cnt;
    logic [1:0]              r_axis;
    logic signed [49:0]      r_p1, r_p2;

    logic                    r_out_valid;
    t_out_item               r_out_data;

    logic signed [DELTA_W-1:0] sat_in;
    logic [1:0]                btn_in;
    logic [ALPHA_W-1:0]        a_lim;
    logic signed [ALPHA_W:0]   a_s, w_s;
    logic signed [31:0]        old_sel, dsh_sel;
    logic signed [50:0]        v_sum;
    logic [SUM_W-1:0]          mag_x, mag_y;
    logic [CNT_W:0]            rsh_x, rsh_y;
    logic                      ge_x, ge_y;

    function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
        if (v > 35'sh0_7FFF_FFFF)       sat35 = 32'sh7FFF_FFFF;
        else if (v < -35'sh0_8000_0000) sat35 = -32'sh8000_0000;
        else                            sat35 = v[31:0];
    endfunction

    function automatic logic signed [31:0] sat_quot(input logic [DVD_W-1:0] q,
                                                    input logic neg);
        if (neg) begin
            if (q > DVD_W'(33'h0_8000_0000)) sat_quot = 32'h8000_0000;
            else                             sat_quot = -q[31:0];
        end else begin
            if (q > DVD_W'(32'h7FFF_FFFF))   sat_quot = 32'h7FFF_FFFF;
            else                             sat_quot = q[31:0];
        end
    endfunction

    // input conditioning
    always_comb begin
        if (i_in_data.ev_value > 32'sd32767)       sat_in = 16'sh7FFF;
        else if (i_in_data.ev_value < -32'sd32768) sat_in = -16'sh8000;
        else                                       sat_in = i_in_data.ev_value[15:0];
        if (i_in_data.ev_value < 0)         btn_in = 2'd0;
        else if (i_in_data.ev_value > 32'sd2) btn_in = 2'd2;
        else                                btn_in = i_in_data.ev_value[1:0];
    end

    assign target = (r_win_sz > 7'(WIN_MAX)) ? CNT_W'(WIN_MAX) : CNT_W'(r_win_sz);
    assign a_lim  = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign a_s    = $signed({1'b0, a_lim});
    assign w_s    = $signed({1'b0, ALPHA_ONE - a_lim});
    assign old_sel = r_smooth[r_axis];
    assign dsh_sel = {r_held[r_axis], 16'h0000};
    assign v_sum   = {r_p1[49], r_p1} + {r_p2[49], r_p2};
    assign mag_x   = r_sum_x < 0 ? SUM_W'(-r_sum_x) : SUM_W'(r_sum_x);
    assign mag_y   = r_sum_y < 0 ? SUM_W'(-r_sum_y) : SUM_W'(r_sum_y);

    // restoring division step, one quotient bit per cycle
    assign rsh_x = {r_rem_x, r_dvd_x[DVD_W-1]};
    assign rsh_y = {r_rem_y, r_dvd_y[DVD_W-1]};
    assign ge_x  = rsh_x >= {1'b0, r_count};
    assign ge_y  = rsh_y >= {1'b0, r_count};

    mems_ram #(.WIDTH(2*DELTA_W), .DEPTH(WIN_MAX)) u_win (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_head + r_count[WIN_AW-1:0]),
        .i_wdata ({r_held[0], r_held[1]}),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= '0;
            r_use_ma <= 1'b0;
            r_win_sz <= 7'd8;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ALPHA:  r_alpha  <= i_cfg_data;
                REG_USE_MA: r_use_ma <= i_cfg_data[0];
                REG_WIN_SZ: r_win_sz <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // held record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= KIND_NONE;
            r_button <= 2'd0;
            r_motion <= 1'b0;
            for (int i = 0; i < 4; i++) r_held[i] <= '0;
        end else if (i_cmd.take_in) begin
            if (i_in_data.func) begin
                r_kind   <= KIND_NONE;
                r_motion <= 1'b0;
            end else if (i_in_data.ev_type == EV_SYN) begin
                r_motion <= 1'b0;
            end else if (i_in_data.ev_type == EV_KEY) begin
                case (i_in_data.ev_code)
                    KEY_RIGHT: r_kind <= KIND_RIGHT;
                    KEY_LEFT:  r_kind <= KIND_LEFT;
                    KEY_KPMIN: r_kind <= KIND_BTN_B;
                    KEY_KPPLS: r_kind <= KIND_BTN_A;
                    default: ;
                endcase
                r_button <= btn_in;
            end else if (i_in_data.ev_type == EV_REL) begin
                case (i_in_data.ev_code)
                    REL_X: begin
                        r_kind    <= KIND_CURSOR;
                        r_held[0] <= sat_in;
                        r_held[1] <= '0;
                        r_motion  <= 1'b1;
                    end
                    REL_Y: begin
                        r_kind    <= KIND_CURSOR;
                        r_held[1] <= sat_in;
                        if (!r_motion) r_held[0] <= '0;
                        r_motion  <= 1'b1;
                    end
                    REL_Z: begin
                        r_kind    <= KIND_CURSOR;
                        r_held[2] <= sat_in;
                        if (!r_motion) begin
                            r_held[0] <= '0;
                            r_held[1] <= '0;
                        end
                        r_motion  <= 1'b1;
                    end
                    REL_WHEEL: begin
                        r_kind    <= KIND_WHEEL;
                        r_held[3] <= sat_in;
                    end
                    default: ;
                endcase
            end
        end
    end

    // window bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_head  <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else if (i_cmd.pop) begin
            r_sum_x <= r_sum_x - SUM_W'($signed(ram_rdata[2*DELTA_W-1:DELTA_W]));
            r_sum_y <= r_sum_y - SUM_W'($signed(ram_rdata[DELTA_W-1:0]));
            r_head  <= r_head + 1'b1;
            r_count <= r_count - 1'b1;
        end else if (i_cmd.push) begin
            r_sum_x <= r_sum_x + SUM_W'(r_held[0]);
            r_sum_y <= r_sum_y + SUM_W'(r_held[1]);
            r_count <= r_count + 1'b1;
        end
    end

    // filters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) r_smooth[i] <= '0;
            r_div_cnt <= '0;
            r_axis    <= '0;
        end else begin
            if (i_cmd.filt_init) begin
                r_axis    <= '0;
                r_div_cnt <= '0;
                if (r_use_ma && r_count == '0) begin
                    // empty window falls back to the held delta
                    r_smooth[0] <= {r_held[0], 16'h0000};
                    r_smooth[1] <= {r_held[1], 16'h0000};
                    r_smooth[2] <= '0;
                end
            end
            if (i_cmd.div_step) r_div_cnt <= r_div_cnt + 1'b1;
            if (i_cmd.div_fin) begin
                r_smooth[0] <= sat_quot(r_dvd_x, r_neg_x);
                r_smooth[1] <= sat_quot(r_dvd_y, r_neg_y);
                r_smooth[2] <= '0;
            end
            if (i_cmd.sm_wr) begin
                r_smooth[r_axis] <= sat35(v_sum[50:16]);
                r_axis           <= r_axis + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.filt_init) begin
            r_dvd_x <= {mag_x, 16'h0000};
            r_dvd_y <= {mag_y, 16'h0000};
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_neg_x <= r_sum_x < 0;
            r_neg_y <= r_sum_y < 0;
        end else if (i_cmd.div_step) begin
            r_rem_x <= ge_x ? CNT_W'(rsh_x - {1'b0, r_count}) : CNT_W'(rsh_x);
            r_rem_y <= ge_y ? CNT_W'(rsh_y - {1'b0, r_count}) : CNT_W'(rsh_y);
            r_dvd_x <= {r_dvd_x[DVD_W-2:0], ge_x};
            r_dvd_y <= {r_dvd_y[DVD_W-2:0], ge_y};
        end
        if (i_cmd.mul) begin
            r_p1 <= a_s * old_sel;
            r_p2 <= w_s * dsh_sel;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data.event_kind   <= r_kind;
            r_out_data.button_state <= r_button;
            r_out_data.rel_x        <= r_held[0];
            r_out_data.rel_y        <= r_held[1];
            r_out_data.rel_z        <= r_held[2];
            r_out_data.rel_scroll   <= r_held[3];
            r_out_data.filtered_x   <= r_smooth[0];
            r_out_data.filtered_y   <= r_smooth[1];
            r_out_data.filtered_z   <= r_smooth[2];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        o_stat.in_emits  = i_in_data.func || i_in_data.ev_type == EV_SYN;
        o_stat.is_cursor = r_kind == KIND_CURSOR;
        o_stat.cnt_gt    = r_count > target;
        o_stat.cnt_lt    = r_count < target;
        o_stat.cnt_zero  = r_count == '0;
        o_stat.use_ma    = r_use_ma;
        o_stat.div_last  = r_div_cnt == DIV_CW'(DVD_W - 1);
        o_stat.axis_last = r_axis == 2'd2;
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    `ASSERT_IMPL(a_cnt_max, 1'b1, r_count <= CNT_W'(WIN_MAX), "window count overrun")
    `ASSERT_NEXT(a_push_cnt, i_cmd.push, r_count == $past(r_count) + 1'b1, "push lost")
    `ASSERT_IMPL(a_no_clobber, i_cmd.load_out, !r_out_valid || !i_out_stall, "result overwritten")

endmodule

`default_nettype wire

// ===== rtl/core/mouse_event_motion_smoother.sv =====
// Key, motion and unknown events are taken in the idle state and give no result.
// Sync or timeout: window update (S_UPD, S_RD, S_POP, S_PUSH as needed), then the filter:
//   smoother (3 axes in turn through one multiply/add pair), mean (two restoring
//   dividers giving 40 quotient bits) or empty-window mean, then the result load.
// One item at a time; the next is taken while the last result waits.
// Synchronous active-low reset clears control, record, sums and filter state.
// ----------------------------------------------------------------------------
// mouse_event_motion_smoother
// Mouse event record with moving-average or exponential motion filter.
// ----------------------------------------------------------------------------
`default_nettype none

module mouse_event_motion_smoother import mems_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_data
);

    t_cmd  cmd;
    t_stat stat;

    mems_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mems_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
